@@ rtl/amsm_pkg.sv @@
// shared constants, codes and types for the arming sequencer and motor mix
package amsm_pkg;

  // throttle request that maps to max_throttle
  localparam int THROTTLE_FULL_SCALE = 512;
  localparam int CORR_LIMIT = 100;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // command codes
  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_PING    = 3'd1;
  localparam logic [2:0] CMD_ENGINES = 3'd2;
  localparam logic [2:0] CMD_TUNING  = 3'd3;
  localparam logic [2:0] CMD_CONTROL = 3'd4;

  // mode codes
  localparam logic [1:0] MODE_ACTIVE     = 2'd0;
  localparam logic [1:0] MODE_TUNING     = 2'd1;
  localparam logic [1:0] MODE_PRECONTROL = 2'd2;
  localparam logic [1:0] MODE_CONTROL    = 2'd3;

  // register indexes
  localparam logic [2:0] REG_ARM_INTERVAL    = 3'd0;
  localparam logic [2:0] REG_DISARM_INTERVAL = 3'd1;
  localparam logic [2:0] REG_TUNING_INTERVAL = 3'd2;
  localparam logic [2:0] REG_PRECONTROL      = 3'd3;
  localparam logic [2:0] REG_LINK_TIMEOUT    = 3'd4;
  localparam logic [2:0] REG_LINK_ENABLE     = 3'd5;
  localparam logic [2:0] REG_MIN_THROTTLE    = 3'd6;
  localparam logic [2:0] REG_MAX_THROTTLE    = 3'd7;

  typedef logic signed [13:0] motor_t;

  typedef struct packed {
    logic [15:0] arm_interval_ms;
    logic [15:0] disarm_interval_ms;
    logic [15:0] tuning_interval_ms;
    logic [15:0] precontrol_delay_ms;
    logic [15:0] link_timeout_ms;
    logic        link_timeout_enable;
    logic [11:0] min_throttle;
    logic [11:0] max_throttle;
  } cfg_t;

endpackage

@@ rtl/amsm_if.sv @@
// request and result channel interfaces
interface amsm_in_if;
  logic              valid;
  logic              ready;
  logic [31:0]       now_ms;
  logic [2:0]        command;
  logic [9:0]        throttle_request;
  logic              motion_update;
  logic signed [7:0] roll_correction;
  logic signed [7:0] pitch_correction;
  logic signed [7:0] yaw_correction;

  modport source (
    output valid, now_ms, command, throttle_request, motion_update,
           roll_correction, pitch_correction, yaw_correction,
    input  ready
  );
  modport sink (
    input  valid, now_ms, command, throttle_request, motion_update,
           roll_correction, pitch_correction, yaw_correction,
    output ready
  );
endinterface

interface amsm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic               motors_running;
  logic               motor_update;
  logic signed [13:0] motor_one;
  logic signed [13:0] motor_two;
  logic signed [13:0] motor_three;
  logic signed [13:0] motor_four;

  modport source (
    output valid, mode, motors_running, motor_update,
           motor_one, motor_two, motor_three, motor_four,
    input  ready
  );
  modport sink (
    input  valid, mode, motors_running, motor_update,
           motor_one, motor_two, motor_three, motor_four,
    output ready
  );
endinterface

@@ rtl/amsm_cfg.sv @@
// configuration register file behind the apb-style port
module amsm_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [amsm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [amsm_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [amsm_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output amsm_pkg::cfg_t             cfg
);

  amsm_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx        = cfg_paddr[amsm_pkg::CFG_AW-1:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.arm_interval_ms     <= 16'd2000;
      cfg_r.disarm_interval_ms  <= 16'd2000;
      cfg_r.tuning_interval_ms  <= 16'd1000;
      cfg_r.precontrol_delay_ms <= 16'd3000;
      cfg_r.link_timeout_ms     <= 16'd1000;
      cfg_r.link_timeout_enable <= 1'b1;
      cfg_r.min_throttle        <= 12'd1000;
      cfg_r.max_throttle        <= 12'd2000;
    end else if (wr_en) begin
      unique case (idx)
        amsm_pkg::REG_ARM_INTERVAL:    cfg_r.arm_interval_ms     <= cfg_pwdata[15:0];
        amsm_pkg::REG_DISARM_INTERVAL: cfg_r.disarm_interval_ms  <= cfg_pwdata[15:0];
        amsm_pkg::REG_TUNING_INTERVAL: cfg_r.tuning_interval_ms  <= cfg_pwdata[15:0];
        amsm_pkg::REG_PRECONTROL:      cfg_r.precontrol_delay_ms <= cfg_pwdata[15:0];
        amsm_pkg::REG_LINK_TIMEOUT:    cfg_r.link_timeout_ms     <= cfg_pwdata[15:0];
        amsm_pkg::REG_LINK_ENABLE:     cfg_r.link_timeout_enable <= cfg_pwdata[0];
        amsm_pkg::REG_MIN_THROTTLE:    cfg_r.min_throttle        <= cfg_pwdata[11:0];
        amsm_pkg::REG_MAX_THROTTLE:    cfg_r.max_throttle        <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      amsm_pkg::REG_ARM_INTERVAL:    cfg_prdata = {16'd0, cfg_r.arm_interval_ms};
      amsm_pkg::REG_DISARM_INTERVAL: cfg_prdata = {16'd0, cfg_r.disarm_interval_ms};
      amsm_pkg::REG_TUNING_INTERVAL: cfg_prdata = {16'd0, cfg_r.tuning_interval_ms};
      amsm_pkg::REG_PRECONTROL:      cfg_prdata = {16'd0, cfg_r.precontrol_delay_ms};
      amsm_pkg::REG_LINK_TIMEOUT:    cfg_prdata = {16'd0, cfg_r.link_timeout_ms};
      amsm_pkg::REG_LINK_ENABLE:     cfg_prdata = {31'd0, cfg_r.link_timeout_enable};
      amsm_pkg::REG_MIN_THROTTLE:    cfg_prdata = {20'd0, cfg_r.min_throttle};
      amsm_pkg::REG_MAX_THROTTLE:    cfg_prdata = {20'd0, cfg_r.max_throttle};
      default:                       cfg_prdata = '0;
    endcase
  end

endmodule

@@ rtl/amsm_mix.sv @@
// throttle mapping, correction clamp and x-quad motor mix
module amsm_mix (
  input  logic              use_map,
  input  logic [9:0]        throttle_request,
  input  logic [11:0]       base_cur,
  input  logic [11:0]       min_throttle,
  input  logic [11:0]       max_throttle,
  input  logic signed [7:0] roll_correction,
  input  logic signed [7:0] pitch_correction,
  input  logic signed [7:0] yaw_correction,
  output logic [11:0]       base_out,
  output amsm_pkg::motor_t  motor [4]
);

  localparam logic [9:0] FULL_SCALE_REQ = 10'(amsm_pkg::THROTTLE_FULL_SCALE);
  localparam logic signed [23:0] FULL_SCALE_S = 24'(amsm_pkg::THROTTLE_FULL_SCALE);
  localparam logic signed [7:0] LIMIT_HI = 8'(amsm_pkg::CORR_LIMIT);
  localparam logic signed [7:0] LIMIT_LO = -8'(amsm_pkg::CORR_LIMIT);

  function automatic logic signed [13:0] clamp_corr(input logic signed [7:0] v);
    logic signed [7:0] c;
    c = v;
    if (v > LIMIT_HI) c = LIMIT_HI;
    if (v < LIMIT_LO) c = LIMIT_LO;
    return {{6{c[7]}}, c};
  endfunction

  logic [9:0]         req_sat;
  logic signed [12:0] span;
  logic signed [23:0] prod;
  logic signed [23:0] quot;
  logic signed [13:0] mapped;
  logic signed [13:0] b14, r14, p14, y14;

  assign req_sat = (throttle_request > FULL_SCALE_REQ) ? FULL_SCALE_REQ : throttle_request;
  assign span    = $signed({1'b0, max_throttle}) - $signed({1'b0, min_throttle});
  assign prod    = $signed({1'b0, req_sat}) * span;
  // signed divide truncates toward zero, full scale is a power of two
  assign quot    = prod / FULL_SCALE_S;
  assign mapped  = $signed({2'b00, min_throttle}) + quot[13:0];

  assign base_out = use_map ? mapped[11:0] : base_cur;

  assign b14 = $signed({2'b00, base_out});
  assign r14 = clamp_corr(roll_correction);
  assign p14 = clamp_corr(pitch_correction);
  assign y14 = clamp_corr(yaw_correction);

  assign motor[0] = b14 + r14 + p14 + y14;
  assign motor[1] = b14 - r14 + p14 - y14;
  assign motor[2] = b14 - r14 - p14 + y14;
  assign motor[3] = b14 + r14 - p14 - y14;

endmodule

@@ rtl/arming_mode_sequencer_with_motor_mix.sv @@
// arming and mode sequencer with x-quad motor mix, top level
//
//   channel   direction  handshake          contents
//   in_chan   sink       valid/ready        time, command, throttle, motion, corrections
//   out_chan  source     valid/ready        mode, running, update, four motor commands
//   cfg_*     slave      psel/penable/pwrite eight timing and throttle registers
//
// one request per cycle sustained while out_chan is ready; each result goes through
// (input register, then mode logic, throttle multiply and mix into the result register)
// the mode and stamp registers update as each request moves into the result register
// reset is synchronous active low and clears mode, stamps, base throttle and motors
// a stalled result holds the input register; requests keep flowing while out_chan is ready
module arming_mode_sequencer_with_motor_mix (
  input  logic                        clk,
  input  logic                        rst_n,
  amsm_in_if.sink                     in_chan,
  amsm_out_if.source                  out_chan,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [amsm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [amsm_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [amsm_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  amsm_pkg::cfg_t cfg;

  amsm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // input register
  logic              s1_valid_r;
  logic [31:0]       s1_now_r;
  logic [2:0]        s1_cmd_r;
  logic [9:0]        s1_req_r;
  logic              s1_motion_r;
  logic signed [7:0] s1_roll_r;
  logic signed [7:0] s1_pitch_r;
  logic signed [7:0] s1_yaw_r;

  // sequencer state, also the result payload
  logic [1:0]       mode_r, mode_nxt;
  logic             running_r, running_nxt;
  logic             update_r, update_nxt;
  logic [31:0]      eng_stamp_r, eng_stamp_nxt;
  logic [31:0]      tun_stamp_r, tun_stamp_nxt;
  logic [31:0]      pc_stamp_r, pc_stamp_nxt;
  logic [31:0]      link_stamp_r, link_stamp_nxt;
  logic [11:0]      base_r, base_nxt;
  amsm_pkg::motor_t motor_r [4];
  amsm_pkg::motor_t motor_nxt [4];
  logic             out_valid_r;

  logic adv;
  logic in_acc;

  assign adv            = s1_valid_r & (~out_valid_r | out_chan.ready);
  assign in_chan.ready  = ~s1_valid_r | adv;
  assign in_acc         = in_chan.valid & in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_now_r    <= in_chan.now_ms;
      s1_cmd_r    <= in_chan.command;
      s1_req_r    <= in_chan.throttle_request;
      s1_motion_r <= in_chan.motion_update;
      s1_roll_r   <= in_chan.roll_correction;
      s1_pitch_r  <= in_chan.pitch_correction;
      s1_yaw_r    <= in_chan.yaw_correction;
    end
  end

  // elapsed times, modulo 2^32
  logic [31:0] d_eng, d_tun, d_pc, d_link;
  assign d_eng  = s1_now_r - eng_stamp_r;
  assign d_tun  = s1_now_r - tun_stamp_r;
  assign d_pc   = s1_now_r - pc_stamp_r;
  assign d_link = s1_now_r - link_stamp_r;

  logic             is_ctl_data;
  logic [11:0]      mix_base;
  amsm_pkg::motor_t mix_motor [4];

  assign is_ctl_data = (s1_cmd_r == amsm_pkg::CMD_CONTROL);

  amsm_mix u_mix (
    .use_map          (is_ctl_data),
    .throttle_request (s1_req_r),
    .base_cur         (base_r),
    .min_throttle     (cfg.min_throttle),
    .max_throttle     (cfg.max_throttle),
    .roll_correction  (s1_roll_r),
    .pitch_correction (s1_pitch_r),
    .yaw_correction   (s1_yaw_r),
    .base_out         (mix_base),
    .motor            (mix_motor)
  );

  always_comb begin
    mode_nxt       = mode_r;
    running_nxt    = running_r;
    update_nxt     = 1'b0;
    eng_stamp_nxt  = eng_stamp_r;
    tun_stamp_nxt  = tun_stamp_r;
    pc_stamp_nxt   = pc_stamp_r;
    link_stamp_nxt = link_stamp_r;
    base_nxt       = base_r;
    for (int k = 0; k < 4; k++) motor_nxt[k] = motor_r[k];

    unique case (mode_r)
      amsm_pkg::MODE_ACTIVE: begin
        // a zero stamp means never toggled
        if (s1_cmd_r == amsm_pkg::CMD_ENGINES) begin
          if (eng_stamp_r == 32'd0 || d_eng > {16'd0, cfg.arm_interval_ms}) begin
            pc_stamp_nxt   = s1_now_r;
            link_stamp_nxt = s1_now_r;
            mode_nxt       = amsm_pkg::MODE_PRECONTROL;
          end
        end else if (s1_cmd_r == amsm_pkg::CMD_TUNING) begin
          if (tun_stamp_r == 32'd0 || d_tun > {16'd0, cfg.tuning_interval_ms}) begin
            tun_stamp_nxt = s1_now_r;
            mode_nxt      = amsm_pkg::MODE_TUNING;
          end
        end
      end
      amsm_pkg::MODE_TUNING: begin
        if (s1_cmd_r == amsm_pkg::CMD_TUNING && d_tun > {16'd0, cfg.tuning_interval_ms}) begin
          tun_stamp_nxt = s1_now_r;
          mode_nxt      = amsm_pkg::MODE_ACTIVE;
        end
      end
      amsm_pkg::MODE_PRECONTROL: begin
        if (d_pc >= {16'd0, cfg.precontrol_delay_ms}) begin
          base_nxt       = cfg.min_throttle;
          running_nxt    = 1'b1;
          eng_stamp_nxt  = s1_now_r;
          link_stamp_nxt = s1_now_r;
          mode_nxt       = amsm_pkg::MODE_CONTROL;
        end
      end
      amsm_pkg::MODE_CONTROL: begin
        if (cfg.link_timeout_enable && d_link > {16'd0, cfg.link_timeout_ms}) begin
          // lost link: command dropped, no motor update
          running_nxt   = 1'b0;
          eng_stamp_nxt = s1_now_r;
          mode_nxt      = amsm_pkg::MODE_ACTIVE;
        end else begin
          if (s1_cmd_r != amsm_pkg::CMD_NONE) begin
            link_stamp_nxt = s1_now_r;
          end
          if (s1_cmd_r == amsm_pkg::CMD_ENGINES &&
              d_eng > {16'd0, cfg.disarm_interval_ms}) begin
            running_nxt   = 1'b0;
            eng_stamp_nxt = s1_now_r;
            mode_nxt      = amsm_pkg::MODE_ACTIVE;
          end else begin
            if (is_ctl_data) base_nxt = mix_base;
            if (s1_motion_r || is_ctl_data) begin
              for (int k = 0; k < 4; k++) motor_nxt[k] = mix_motor[k];
              update_nxt = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= amsm_pkg::MODE_ACTIVE;
      running_r    <= 1'b0;
      update_r     <= 1'b0;
      eng_stamp_r  <= '0;
      tun_stamp_r  <= '0;
      pc_stamp_r   <= '0;
      link_stamp_r <= '0;
      base_r       <= '0;
      for (int k = 0; k < 4; k++) motor_r[k] <= '0;
    end else if (adv) begin
      mode_r       <= mode_nxt;
      running_r    <= running_nxt;
      update_r     <= update_nxt;
      eng_stamp_r  <= eng_stamp_nxt;
      tun_stamp_r  <= tun_stamp_nxt;
      pc_stamp_r   <= pc_stamp_nxt;
      link_stamp_r <= link_stamp_nxt;
      base_r       <= base_nxt;
      for (int k = 0; k < 4; k++) motor_r[k] <= motor_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.mode           = mode_r;
  assign out_chan.motors_running = running_r;
  assign out_chan.motor_update   = update_r;
  assign out_chan.motor_one      = motor_r[0];
  assign out_chan.motor_two      = motor_r[1];
  assign out_chan.motor_three    = motor_r[2];
  assign out_chan.motor_four     = motor_r[3];

  // motors only run in control mode
  a_running_mode: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (mode_r == amsm_pkg::MODE_CONTROL))
    else $error("motors running outside control mode");

  // a motor update only comes from control mode with motors started
  a_update_ctl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && update_r) |-> (mode_r == amsm_pkg::MODE_CONTROL && running_r))
    else $error("motor update outside control mode");

  // an empty result register never blocks the input side
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_chan.ready)
    else $error("input stalled with empty result register");

  // a moved request always leaves a result behind
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("result lost after advance");

endmodule
